@@ design/gripper_contact_detector_unit_defines.svh @@
// Assertion helpers for the gripper contact detector.
`ifndef GRIPPER_CONTACT_DETECTOR_UNIT_DEFINES_SVH
`define GRIPPER_CONTACT_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define GCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define GCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/gcd_pkg.sv @@
`timescale 1ns / 1ps

package gcd_pkg;

   // Default sizing
   localparam int WINDOW_MAX_DEF  = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   // Field widths
   localparam int POS_W      = 16;
   localparam int TORQUE_W   = 16;
   localparam int WIN_W      = 6;
   localparam int MIN_ERR_W  = 16;
   localparam int CONV_W     = 17;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CLASS_W    = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TORQUE_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_POS_ERROR    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CONV_THRESHOLD   = 2'd3;

   // Reset values
   localparam logic [WIN_W-1:0]            WINDOW_SIZE_RST = 6'd8;
   localparam logic signed [TORQUE_W-1:0]  TORQUE_THR_RST  = 16'sh7FFF;
   localparam logic [MIN_ERR_W-1:0]        MIN_ERR_RST     = 16'd0;
   localparam logic signed [CONV_W-1:0]    CONV_THR_RST    = 17'sd0;

   // Contact class codes
   localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_TORQUE = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_POS    = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_BOTH   = 2'd3;

   // Item kinds carried in tuser
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   typedef struct packed {
      logic [WIN_W-1:0]           win_len;
      logic signed [TORQUE_W-1:0] torque_threshold;
      logic [MIN_ERR_W-1:0]       min_position_error;
      logic signed [CONV_W-1:0]   convergence_threshold;
   } cfg_type;

endpackage

@@ design/gripper_contact_detector_unit.sv @@
`timescale 1ns / 1ps
// Gripper contact detector. Each sample item (tuser low) carries commanded
// position, measured position and torque; the block forms the absolute
// position error, keeps the most recent errors in a window of programmable
// length, and answers every item with exactly one result item: contact_class
// (none, torque only, position only, both) and in_contact. Torque contact is
// torque above its threshold; stall contact is an error above
// min_position_error, a full window, and oldest minus newest error below
// convergence_threshold. A clear item (tuser high) empties the window and
// answers class none; writing the window length register empties it too.
// Throughput is one item per clock while the result channel is not stalled;
// an accepted item passes the input register, then the result register fed by
// the registered read port of the error ring. Write registers only while idle.

`include "gripper_contact_detector_unit_defines.svh"

module gripper_contact_detector_unit #(
   parameter int WINDOW_MAX  = gcd_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = gcd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input item channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: [15:0] commanded_position, [31:16] measured_position,
   //        [47:32] torque_feedback
   input  logic [47:0]                        req_tdata,
   // tuser: [0] action
   input  logic                               req_tuser,
   // Result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: [1:0] contact_class, [2] in_contact, [7:3] zero
   output logic [7:0]                         rsp_tdata,
   // Configuration write port
   input  logic                               csr_we,
   input  logic [gcd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gcd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int DEL_W = SAMPLE_BITS + 1;
   localparam int CMP_W = (DEL_W > gcd_pkg::CONV_W) ? DEL_W : gcd_pkg::CONV_W;

   gcd_pkg::cfg_type cfg;
   logic             win_clear;

   // Stage A: input register
   logic                                 a_valid_ff, a_valid_in;
   logic                                 a_action_ff;
   logic signed [gcd_pkg::POS_W-1:0]     a_cmd_ff, a_meas_ff;
   logic signed [gcd_pkg::TORQUE_W-1:0]  a_tau_ff;

   // Stage B: result register
   logic                                 b_valid_ff, b_valid_in;
   logic                                 b_tau_hit_ff, b_check_ff, b_same_ff;
   logic [SAMPLE_BITS-1:0]               b_newest_ff;

   logic                                 req_take, a_step, b_free;
   logic [SAMPLE_BITS-1:0]               err, oldest;
   logic                                 wr_en, check_pos, same_slot;
   logic [PTR_W-1:0]                     wr_addr, rd_addr;
   logic [CNT_W-1:0]                     fill_count, window_eff;
   logic signed [DEL_W-1:0]              delta;
   logic signed [CMP_W-1:0]              delta_ext, conv_ext;
   logic                                 pos_hit;
   logic [gcd_pkg::CLASS_W-1:0]          contact_class;

   gcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .win_clear (win_clear)
   );

   // Handshake: stage B frees when empty or being taken; A moves into B
   assign b_free     = !b_valid_ff || rsp_tready;
   assign a_step     = a_valid_ff && b_free;
   assign req_tready = !a_valid_ff || b_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
      end else if (a_step) begin
         a_valid_in = 1'b0;
      end
      b_valid_in = b_valid_ff;
      if (a_step) begin
         b_valid_in = 1'b1;
      end else if (rsp_tready) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Capture the item fields
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_action_ff <= req_tuser;
         a_cmd_ff    <= $signed(req_tdata[15:0]);
         a_meas_ff   <= $signed(req_tdata[31:16]);
         a_tau_ff    <= $signed(req_tdata[47:32]);
      end
   end

   gcd_track #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_track (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .win_clear          (win_clear),
      .step               (a_step),
      .action             (a_action_ff),
      .commanded_position (a_cmd_ff),
      .measured_position  (a_meas_ff),
      .err                (err),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .rd_addr            (rd_addr),
      .check_pos          (check_pos),
      .same_slot          (same_slot),
      .fill_count         (fill_count),
      .window_eff         (window_eff)
   );

   // Push the new error and fetch the oldest one in the same cycle
   gcd_ring #(
      .DEPTH (WINDOW_MAX),
      .WIDTH (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (err),
      .rd_en   (a_step),
      .rd_addr (rd_addr),
      .rd_data (oldest)
   );

   // Hold the flags with the result; a clear item carries none
   always_ff @(posedge clock) begin
      if (a_step) begin
         b_tau_hit_ff <= (a_action_ff == gcd_pkg::ACTION_SAMPLE)
                         && (a_tau_ff > cfg.torque_threshold);
         b_check_ff   <= check_pos;
         b_same_ff    <= same_slot;
         b_newest_ff  <= err;
      end
   end

   // Stall test: a one-deep window compares the newest error with itself
   always_comb begin
      delta     = $signed({1'b0, (b_same_ff ? b_newest_ff : oldest)})
                  - $signed({1'b0, b_newest_ff});
      delta_ext = CMP_W'(delta);
      conv_ext  = CMP_W'(cfg.convergence_threshold);
      pos_hit   = b_check_ff && (delta_ext < conv_ext);
      case ({pos_hit, b_tau_hit_ff})
         2'b01:   contact_class = gcd_pkg::CLASS_TORQUE;
         2'b10:   contact_class = gcd_pkg::CLASS_POS;
         2'b11:   contact_class = gcd_pkg::CLASS_BOTH;
         default: contact_class = gcd_pkg::CLASS_NONE;
      endcase
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {5'd0, (contact_class != gcd_pkg::CLASS_NONE), contact_class};

   // Window bookkeeping stays inside the effective window
   `GCD_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, (fill_count <= window_eff) && (CNT_W'(wr_addr) < window_eff), "window fill or pointer beyond effective window")
   // A clear item answers class none on the next cycle
   `GCD_ASSERT_NEXT(a_clear_none, clock, reset, a_step && (a_action_ff == gcd_pkg::ACTION_CLEAR), rsp_tvalid && (rsp_tdata[1:0] == gcd_pkg::CLASS_NONE), "clear item gave a contact result")
   // Writing the window length empties the window
   `GCD_ASSERT_NEXT(a_cfg_clear, clock, reset, win_clear, fill_count == '0, "window not emptied by window length write")

endmodule

@@ design/gcd_csr.sv @@
`timescale 1ns / 1ps

module gcd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gcd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gcd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output gcd_pkg::cfg_type                   cfg,
   output logic                               win_clear
);

   gcd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in    = cfg_ff;
      win_clear = 1'b0;
      if (csr_we) begin
         case (csr_index)
            gcd_pkg::REG_WINDOW_SIZE: begin
               cfg_in.win_len = csr_wdata[gcd_pkg::WIN_W-1:0];
               win_clear      = 1'b1;
            end
            gcd_pkg::REG_TORQUE_THRESHOLD: begin
               cfg_in.torque_threshold = $signed(csr_wdata[gcd_pkg::TORQUE_W-1:0]);
            end
            gcd_pkg::REG_MIN_POS_ERROR: begin
               cfg_in.min_position_error = csr_wdata[gcd_pkg::MIN_ERR_W-1:0];
            end
            gcd_pkg::REG_CONV_THRESHOLD: begin
               cfg_in.convergence_threshold = $signed(csr_wdata[gcd_pkg::CONV_W-1:0]);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_len               <= gcd_pkg::WINDOW_SIZE_RST;
         cfg_ff.torque_threshold      <= gcd_pkg::TORQUE_THR_RST;
         cfg_ff.min_position_error    <= gcd_pkg::MIN_ERR_RST;
         cfg_ff.convergence_threshold <= gcd_pkg::CONV_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/gcd_ring.sv @@
`timescale 1ns / 1ps

module gcd_ring #(
   parameter int DEPTH = gcd_pkg::WINDOW_MAX_DEF,
   parameter int WIDTH = gcd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read-before-write: a colliding read returns the old entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/gcd_track.sv @@
`timescale 1ns / 1ps

module gcd_track #(
   parameter int WINDOW_MAX  = gcd_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = gcd_pkg::SAMPLE_BITS_DEF,
   localparam int PTR_W      = $clog2(WINDOW_MAX),
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gcd_pkg::cfg_type                  cfg,
   input  logic                              win_clear,
   input  logic                              step,
   input  logic                              action,
   input  logic signed [gcd_pkg::POS_W-1:0]  commanded_position,
   input  logic signed [gcd_pkg::POS_W-1:0]  measured_position,
   output logic [SAMPLE_BITS-1:0]            err,
   output logic                              wr_en,
   output logic [PTR_W-1:0]                  wr_addr,
   output logic [PTR_W-1:0]                  rd_addr,
   output logic                              check_pos,
   output logic                              same_slot,
   output logic [CNT_W-1:0]                  fill_count,
   output logic [CNT_W-1:0]                  window_eff
);

   localparam int DIFF_W = gcd_pkg::POS_W + 1;
   localparam int SAT_W  = (SAMPLE_BITS > DIFF_W) ? SAMPLE_BITS : DIFF_W;
   localparam int WS_W   = (CNT_W > gcd_pkg::WIN_W) ? CNT_W : gcd_pkg::WIN_W;
   localparam int MIN_W  = (SAMPLE_BITS > gcd_pkg::MIN_ERR_W) ? SAMPLE_BITS
                                                              : gcd_pkg::MIN_ERR_W;

   logic [PTR_W-1:0]         wp_ff, wp_in, wp_next;
   logic [CNT_W-1:0]         fill_ff, fill_in, fill_next, wp_inc;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        diff_abs;
   logic [WS_W-1:0]          ws_ext, wmax_ext, win_sel;

   // Effective window: zero reads as one, large values clip at the ring depth
   always_comb begin
      ws_ext   = WS_W'(cfg.win_len);
      wmax_ext = WS_W'(WINDOW_MAX);
      if (ws_ext == '0) begin
         win_sel = WS_W'(1);
      end else if (ws_ext > wmax_ext) begin
         win_sel = wmax_ext;
      end else begin
         win_sel = ws_ext;
      end
      window_eff = win_sel[CNT_W-1:0];
   end

   // Absolute position error, clipped to the stored width
   always_comb begin
      diff     = DIFF_W'(commanded_position) - DIFF_W'(measured_position);
      diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      if (SAT_W'(diff_abs) > SAT_W'({SAMPLE_BITS{1'b1}})) begin
         err = {SAMPLE_BITS{1'b1}};
      end else begin
         err = SAMPLE_BITS'(diff_abs);
      end
   end

   always_comb begin
      wp_inc    = CNT_W'(wp_ff) + CNT_W'(1);
      wp_next   = (wp_inc >= window_eff) ? '0 : wp_inc[PTR_W-1:0];
      fill_next = (fill_ff < window_eff) ? fill_ff + CNT_W'(1) : fill_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      if (win_clear) begin
         wp_in   = '0;
         fill_in = '0;
      end else if (step) begin
         if (action == gcd_pkg::ACTION_CLEAR) begin
            wp_in   = '0;
            fill_in = '0;
         end else begin
            wp_in   = wp_next;
            fill_in = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   assign wr_en      = step && (action == gcd_pkg::ACTION_SAMPLE);
   assign wr_addr    = wp_ff;
   assign rd_addr    = wp_next;
   assign same_slot  = (wp_next == wp_ff);
   assign check_pos  = (action == gcd_pkg::ACTION_SAMPLE)
                       && (MIN_W'(err) > MIN_W'(cfg.min_position_error))
                       && (fill_next == window_eff);
   assign fill_count = fill_ff;

endmodule
